### rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HCA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hca: check failed");

// next-cycle implication, checked outside reset
`define HCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hca: check failed");

`endif

### rtl/hca_pkg.sv
// shared constants and types of the heightmap corner averager
`timescale 1ns / 1ps
`default_nettype none

package hca_pkg;

    // default memory and image limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // field widths
    localparam int PIX_W  = 8;
    localparam int POS_W  = 11;
    localparam int GAIN_W = 16;
    localparam int HGT_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd2;

    // register reset values
    localparam logic [POS_W-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [POS_W-1:0]  HEIGHT_RST = 11'd1024;
    localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd256;

    // vertex slots of one pixel, in emission order
    localparam logic [1:0] K_OWN    = 2'd0;
    localparam logic [1:0] K_RIGHT  = 2'd1;
    localparam logic [1:0] K_BOTTOM = 2'd2;
    localparam logic [1:0] K_CORNER = 2'd3;

    // one accepted pixel with its position flags
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             first_row;
        logic             first_col;
        logic             last_col;
        logic             last_row;
    } pix_item_t;

    // one vertex waiting for scaling
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] mean;
        logic             last;
    } vtx_req_t;

endpackage

`default_nettype wire

### rtl/hca_row_mem.sv
// previous-row pixel memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module hca_row_mem #(
    parameter int DEPTH = hca_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic [hca_pkg::PIX_W-1:0] wr_data,
    input  wire logic                     rd_en,
    input  wire logic [AW-1:0]            rd_addr,
    output logic      [hca_pkg::PIX_W-1:0] rd_data
);

    logic [hca_pkg::PIX_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/hca_vertex_seq.sv
// neighbour assembly, corner means and per-pixel vertex sequencing
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hca_vertex_seq #(
    parameter int AW = $clog2(hca_pkg::MAX_WIDTH_DEF)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // pixel from the fetch stage, memory data aligned with it
    input  wire logic                      item_valid,
    input  wire hca_pkg::pix_item_t        item,
    input  wire logic [hca_pkg::PIX_W-1:0] up_data,
    output logic                           item_ready,
    // live image size
    input  wire logic [hca_pkg::POS_W-1:0] w_eff,
    input  wire logic [hca_pkg::POS_W-1:0] h_eff,
    // row memory write back
    output logic                           mem_wr_en,
    output logic [AW-1:0]                  mem_wr_addr,
    output logic [hca_pkg::PIX_W-1:0]      mem_wr_data,
    // vertex towards the scaler
    output logic                           vtx_valid,
    output hca_pkg::vtx_req_t              vtx,
    input  wire logic                      vtx_ready
);

    logic                      b_valid_reg, b_valid_next;
    logic [1:0]                b_k_reg, b_k_next;
    hca_pkg::pix_item_t        b_item_reg;
    logic [hca_pkg::PIX_W-1:0] b_mean_reg [4];
    logic [hca_pkg::PIX_W-1:0] left_reg, up_left_reg;

    logic                      load, issue, seq_done;
    logic [1:0]                k_after;
    logic [hca_pkg::PIX_W-1:0] up, left, up_left;
    logic [hca_pkg::PIX_W+1:0] sum4;
    logic [hca_pkg::PIX_W:0]   sum_right, sum_bottom;

    // neighbours with edge clamping
    always_comb
    begin
        if (item.first_row)
        begin
            up      = item.pixel;
            up_left = left_reg;
        end
        else
        begin
            up      = up_data;
            up_left = up_left_reg;
        end
        left = left_reg;
        if (item.first_col)
        begin
            left    = item.pixel;
            up_left = up;
        end
    end

    // corner sums
    assign sum4 = 10'(up_left) + 10'(up) + 10'(left) + 10'(item.pixel);
    assign sum_right  = 9'(up) + 9'(item.pixel);
    assign sum_bottom = 9'(left) + 9'(item.pixel);

    // next vertex slot of the current pixel
    always_comb
    begin
        k_after  = hca_pkg::K_OWN;
        seq_done = 1'b1;
        case (b_k_reg)
            hca_pkg::K_OWN:
            begin
                if (b_item_reg.last_col)
                begin
                    k_after  = hca_pkg::K_RIGHT;
                    seq_done = 1'b0;
                end
                else if (b_item_reg.last_row)
                begin
                    k_after  = hca_pkg::K_BOTTOM;
                    seq_done = 1'b0;
                end
            end
            hca_pkg::K_RIGHT:
            begin
                if (b_item_reg.last_row)
                begin
                    k_after  = hca_pkg::K_BOTTOM;
                    seq_done = 1'b0;
                end
            end
            hca_pkg::K_BOTTOM:
            begin
                if (b_item_reg.last_col)
                begin
                    k_after  = hca_pkg::K_CORNER;
                    seq_done = 1'b0;
                end
            end
            default:
            begin
                k_after  = hca_pkg::K_OWN;
                seq_done = 1'b1;
            end
        endcase
    end

    // handshake between fetch and vertex stage
    assign issue      = b_valid_reg && vtx_ready;
    assign item_ready = !b_valid_reg || (vtx_ready && seq_done);
    assign load       = item_valid && item_ready;

    always_comb
    begin
        b_valid_next = b_valid_reg;
        b_k_next     = b_k_reg;
        if (load)
        begin
            b_valid_next = 1'b1;
            b_k_next     = hca_pkg::K_OWN;
        end
        else if (issue)
        begin
            if (seq_done)
            begin
                b_valid_next = 1'b0;
            end
            else
            begin
                b_k_next = k_after;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_k_reg     <= hca_pkg::K_OWN;
            left_reg    <= '0;
            up_left_reg <= '0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            b_k_reg     <= b_k_next;
            if (load)
            begin
                left_reg    <= item.pixel;
                up_left_reg <= up;
            end
        end
    end

    // payload of the pixel being expanded
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b_item_reg                  <= item;
            b_mean_reg[hca_pkg::K_OWN]    <= sum4[hca_pkg::PIX_W+1:2];
            b_mean_reg[hca_pkg::K_RIGHT]  <= sum_right[hca_pkg::PIX_W:1];
            b_mean_reg[hca_pkg::K_BOTTOM] <= sum_bottom[hca_pkg::PIX_W:1];
            b_mean_reg[hca_pkg::K_CORNER] <= item.pixel;
        end
    end

    // row memory takes the current pixel
    assign mem_wr_en   = load;
    assign mem_wr_addr = AW'(item.col);
    assign mem_wr_data = item.pixel;

    // vertex out
    assign vtx_valid = b_valid_reg;
    assign vtx.row   = b_k_reg[1] ? h_eff : b_item_reg.row;
    assign vtx.col   = b_k_reg[0] ? w_eff : b_item_reg.col;
    assign vtx.mean  = b_mean_reg[b_k_reg];
    assign vtx.last  = seq_done;

    // the outer corner vertex only on the last row and column
    `HCA_ASSERT_NOW(a_corner_only_at_end, b_valid_reg && (b_k_reg == hca_pkg::K_CORNER),
        b_item_reg.last_col && b_item_reg.last_row)
    // an unfinished pixel keeps the stage busy
    `HCA_ASSERT_NEXT(a_stage_holds, issue && !seq_done && !load, b_valid_reg)

endmodule

`default_nettype wire

### rtl/hca_scale_out.sv
// gain multiply and output register
`timescale 1ns / 1ps
`default_nettype none

module hca_scale_out (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       vtx_valid,
    input  wire hca_pkg::vtx_req_t          vtx,
    output logic                            vtx_ready,
    input  wire logic [hca_pkg::GAIN_W-1:0] gain,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [hca_pkg::POS_W-1:0]  vertex_row,
    output logic      [hca_pkg::POS_W-1:0]  vertex_col,
    output logic      [hca_pkg::HGT_W-1:0]  vertex_height,
    output logic                            last_of_run
);

    logic o_valid_reg, o_valid_next;
    logic take;

    assign vtx_ready = !o_valid_reg || out_ready;
    assign take      = vtx_valid && vtx_ready;

    always_comb
    begin
        o_valid_next = o_valid_reg;
        if (take)
        begin
            o_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
        end
    end

    // mean times q8.8 gain, 8 fractional bits kept
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            vertex_row    <= vtx.row;
            vertex_col    <= vtx.col;
            vertex_height <= hca_pkg::HGT_W'(vtx.mean) * hca_pkg::HGT_W'(gain);
            last_of_run   <= vtx.last;
        end
    end

    assign out_valid = o_valid_reg;

endmodule

`default_nettype wire

### rtl/heightmap_corner_average.sv
// top level: configuration, raster counters, row memory fetch and output
//
// channel   | dir | handshake             | beat
// ----------+-----+-----------------------+------------------------------------
// pixel in  | in  | in_valid / in_ready   | pixel
// vertex    | out | out_valid / out_ready | vertex_row, vertex_col, height, last
// config    | in  | cfg_write_en          | cfg_index, cfg_data
//
// one pixel beat per cycle while the vertex sequencer accepts; a pixel yields
// one to four vertex beats, one per cycle while out_ready is high, so a pixel
// of the last column or last row holds it for its extra beats; an input beat
// passes the row memory read, mean stage and multiply and output register
// reset clears counters, neighbour pixels and valids; the row memory is
// not cleared and each entry is written before the next row reads it
// a stall at out_ready backs up through each stage, one beat held per stage
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module heightmap_corner_average #(
    parameter int MAX_WIDTH  = hca_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hca_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_write_en,
    input  wire logic [hca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hca_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel stream
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [hca_pkg::PIX_W-1:0]      pixel,
    // vertex stream
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [hca_pkg::POS_W-1:0]      vertex_row,
    output logic      [hca_pkg::POS_W-1:0]      vertex_col,
    output logic      [hca_pkg::HGT_W-1:0]      vertex_height,
    output logic                                last_of_run
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [hca_pkg::POS_W-1:0]  width_reg, height_reg;
    logic [hca_pkg::GAIN_W-1:0] gain_reg;
    logic [hca_pkg::POS_W-1:0]  w_eff, h_eff;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic               a_valid_reg, a_valid_next;
    hca_pkg::pix_item_t a_item_reg, a_item_next;
    logic               accept, seq_ready;
    logic               at_last_col, at_last_row;

    logic                      mem_wr_en;
    logic [CW-1:0]             mem_wr_addr;
    logic [hca_pkg::PIX_W-1:0] mem_wr_data, mem_rd_data;

    logic              vtx_valid, vtx_ready;
    hca_pkg::vtx_req_t vtx;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= hca_pkg::WIDTH_RST;
            height_reg <= hca_pkg::HEIGHT_RST;
            gain_reg   <= hca_pkg::GAIN_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                hca_pkg::REG_WIDTH:  width_reg  <= cfg_data[hca_pkg::POS_W-1:0];
                hca_pkg::REG_HEIGHT: height_reg <= cfg_data[hca_pkg::POS_W-1:0];
                hca_pkg::REG_GAIN:   gain_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    // image size clamped to two and the memory limits
    always_comb
    begin
        w_eff = width_reg;
        if (width_reg < 11'd2)
        begin
            w_eff = 11'd2;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = hca_pkg::POS_W'(MAX_WIDTH);
        end
        h_eff = height_reg;
        if (height_reg < 11'd2)
        begin
            h_eff = 11'd2;
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = hca_pkg::POS_W'(MAX_HEIGHT);
        end
    end

    // raster position of the incoming pixel
    assign at_last_col = (32'(col_reg) + 32'd1) >= 32'(w_eff);
    assign at_last_row = (32'(row_reg) + 32'd1) >= 32'(h_eff);

    assign in_ready = !a_valid_reg || seq_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        a_item_next.pixel     = pixel;
        a_item_next.row       = hca_pkg::POS_W'(row_reg);
        a_item_next.col       = hca_pkg::POS_W'(col_reg);
        a_item_next.first_row = (row_reg == '0);
        a_item_next.first_col = (col_reg == '0);
        a_item_next.last_col  = at_last_col;
        a_item_next.last_row  = at_last_row;
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (seq_ready)
        begin
            a_valid_next = 1'b0;
        end
    end

    // counters and fetch stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            a_valid_reg <= a_valid_next;
        end
    end

    // fetch stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg <= a_item_next;
        end
    end

    // previous row, read as the pixel is accepted
    hca_row_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_row_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (mem_rd_data)
    );

    hca_vertex_seq #(
        .AW (CW)
    ) u_vertex_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (a_valid_reg),
        .item        (a_item_reg),
        .up_data     (mem_rd_data),
        .item_ready  (seq_ready),
        .w_eff       (w_eff),
        .h_eff       (h_eff),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .vtx_valid   (vtx_valid),
        .vtx         (vtx),
        .vtx_ready   (vtx_ready)
    );

    hca_scale_out u_scale_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .vtx_valid     (vtx_valid),
        .vtx           (vtx),
        .vtx_ready     (vtx_ready),
        .gain          (gain_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .vertex_row    (vertex_row),
        .vertex_col    (vertex_col),
        .vertex_height (vertex_height),
        .last_of_run   (last_of_run)
    );

    // column counter stays inside the row memory
    `HCA_ASSERT_NOW(a_col_in_range, 1'b1, 32'(col_reg) < 32'(MAX_WIDTH))
    // row counter stays inside the image limit
    `HCA_ASSERT_NOW(a_row_in_range, 1'b1, 32'(row_reg) < 32'(MAX_HEIGHT))

endmodule

`default_nettype wire
